[sv/acfc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the AC fan and compressor relay controller.
// Depends on nothing; every other file of the block imports it.
package acfc_pkg;

  // Field widths fixed by the item format.
  localparam int TEMP_IN_W = 12;
  localparam int DEB_W     = 16;
  localparam int DELAY_W   = 18;
  localparam int HYST_W    = 8;
  localparam int RUN_W     = 24;
  localparam int MS_W      = 10;
  localparam int CFG_IDX_W = 32;
  localparam int CFG_DAT_W = 18;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS    = 32'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMP_ON_DELAY     = 32'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAN_OFF_DELAY     = 32'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_CYCLE_DELAY = 32'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS_HALF   = 32'd4;

  // Configuration reset values.
  localparam logic [DEB_W-1:0]   DEBOUNCE_RST    = 16'd100;
  localparam logic [DELAY_W-1:0] COMP_ON_RST     = 18'd5000;
  localparam logic [DELAY_W-1:0] FAN_OFF_RST     = 18'd5000;
  localparam logic [DELAY_W-1:0] SHORT_CYCLE_RST = 18'd180000;
  localparam logic [HYST_W-1:0]  HYST_RST        = 8'd8;

  // Operating mode codes.
  localparam logic [1:0] MODE_AUTO      = 2'd0;
  localparam logic [1:0] MODE_FAN       = 2'd1;
  localparam logic [1:0] MODE_COOL      = 2'd2;
  localparam logic [1:0] MODE_NO_ACTION = 2'd3;

  // System state codes; only "on" lets the relays run.
  localparam logic [1:0] SYS_ON = 2'd0;

  // Return sensor error codes (-127 C and 85 C in 1/16 C).
  localparam logic signed [TEMP_IN_W-1:0] ERR_LOW_CODE  = -12'sd2032;
  localparam logic signed [TEMP_IN_W-1:0] ERR_HIGH_CODE = 12'sd1360;

  // Power-on return temperature, 24 C.
  localparam int RETURN_TEMP_RST = 384;

  localparam logic [MS_W-1:0]  MS_MAX        = 10'd1023;
  localparam logic [MS_W-1:0]  MS_PER_SECOND = 10'd1000;
  localparam logic [RUN_W-1:0] RUN_MAX       = 24'hFFFFFF;

  // Relay request for one tick, in the order the relays are driven.
  typedef enum logic [2:0] {
    ACT_HOLD,      // nothing requested
    ACT_ALL_OFF,   // fan off, then compressor off
    ACT_FAN_ONLY,  // fan on, then compressor off
    ACT_FAN_HOLD,  // fan on, compressor untouched
    ACT_COOL_ON,   // fan on, then compressor on
    ACT_AUTO_OFF,  // compressor off, then fan off
    ACT_AUTO_ON    // compressor on, then fan on
  } action_e;

  typedef struct packed {
    logic [DELAY_W-1:0] comp_on_delay;
    logic [DELAY_W-1:0] fan_stop_delay;
    logic [DELAY_W-1:0] short_cycle_delay;
  } relay_cfg_t;

  typedef struct packed {
    logic             fan;
    logic             comp;
    logic [RUN_W-1:0] run_seconds;
  } relay_out_t;

endpackage

[sv/acfc_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the relay controller: input items,
// result items and configuration writes. Depends on acfc_pkg.
interface acfc_in_if;
  import acfc_pkg::*;
  logic                        valid;
  logic                        ready;
  logic                        float_pin_level;
  logic signed [TEMP_IN_W-1:0] return_sample;
  logic signed [TEMP_IN_W-1:0] room_temperature;
  logic signed [TEMP_IN_W-1:0] setpoint;
  logic                        use_room_temperature;
  logic [1:0]                  operating_mode;
  logic [1:0]                  unit_state;
  logic                        alarm_active;
  logic                        link_lockout;

  modport source (
    output valid, float_pin_level, return_sample, room_temperature, setpoint,
           use_room_temperature, operating_mode, unit_state, alarm_active,
           link_lockout,
    input  ready
  );
  modport sink (
    input  valid, float_pin_level, return_sample, room_temperature, setpoint,
           use_room_temperature, operating_mode, unit_state, alarm_active,
           link_lockout,
    output ready
  );
endinterface

interface acfc_out_if;
  import acfc_pkg::*;
  logic             valid;
  logic             ready;
  logic             fan_drive;
  logic             comp_drive;
  logic             float_closed;
  logic [RUN_W-1:0] run_seconds;

  modport source (
    output valid, fan_drive, comp_drive, float_closed, run_seconds,
    input  ready
  );
  modport sink (
    input  valid, fan_drive, comp_drive, float_closed, run_seconds,
    output ready
  );
endinterface

interface acfc_cfg_if;
  import acfc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

[sv/acfc_float_deb.sv]
`timescale 1ns / 1ps
// Debouncer for the active-low drain float switch.
// Depends on acfc_pkg.
module acfc_float_deb (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic                       pin_level_i,
  input  logic [acfc_pkg::DEB_W-1:0] debounce_ticks_i,
  output logic                       stable_o
);
  import acfc_pkg::*;

  logic             last_raw_q, last_raw_d;
  logic             stable_q, stable_d;
  logic [DEB_W-1:0] timer_q, timer_d;
  logic [DEB_W-1:0] timer_now;
  logic             closed_now;

  always_comb begin
    closed_now = ~pin_level_i;
    last_raw_d = closed_now;
    // A level change restarts the stability count in this very tick.
    timer_now  = (closed_now != last_raw_q) ? '0 : timer_q;
    stable_d   = (timer_now >= debounce_ticks_i) ? closed_now : stable_q;
    timer_d    = (timer_now == '1) ? timer_now : timer_now + 1'b1;
  end

  assign stable_o = stable_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q <= 1'b0;
      stable_q   <= 1'b0;
      timer_q    <= '0;
    end else if (step_i) begin
      last_raw_q <= last_raw_d;
      stable_q   <= stable_d;
      timer_q    <= timer_d;
    end
  end

endmodule

[sv/acfc_temp_track.sv]
`timescale 1ns / 1ps
// Keeps the last valid return air temperature, skipping sensor error codes.
// Depends on acfc_pkg.
module acfc_temp_track #(
  parameter int TEMP_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  step_i,
  input  logic signed [acfc_pkg::TEMP_IN_W-1:0] return_sample_i,
  output logic signed [TEMP_BITS-1:0]           ret_temp_o
);
  import acfc_pkg::*;

  logic signed [TEMP_BITS-1:0] temp_q, temp_d;
  logic                        sample_ok;

  always_comb begin
    sample_ok = (return_sample_i != ERR_LOW_CODE) && (return_sample_i != ERR_HIGH_CODE);
    temp_d    = sample_ok ? TEMP_BITS'(return_sample_i) : temp_q;
  end

  assign ret_temp_o = temp_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q <= TEMP_BITS'(RETURN_TEMP_RST);
    end else if (step_i) begin
      temp_q <= temp_d;
    end
  end

endmodule

[sv/acfc_relay.sv]
`timescale 1ns / 1ps
// Fan and compressor relay sequencing with delay timers and run-second count.
// Depends on acfc_pkg.
module acfc_relay #(
  parameter int TIMER_BITS = 18
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  acfc_pkg::action_e      action_i,
  input  logic                   float_stable_i,
  input  acfc_pkg::relay_cfg_t   cfg_i,
  output acfc_pkg::relay_out_t   out_o
);
  import acfc_pkg::*;

  localparam int CMP_TW = (TIMER_BITS > DELAY_W) ? TIMER_BITS : DELAY_W;

  typedef struct packed {
    logic                  fan;
    logic                  comp;
    logic [TIMER_BITS-1:0] since_off;
    logic [TIMER_BITS-1:0] since_fan;
    logic [RUN_W-1:0]      run;
  } rl_t;

  function automatic logic reached(logic [TIMER_BITS-1:0] t, logic [DELAY_W-1:0] d);
    return CMP_TW'(t) >= CMP_TW'(d);
  endfunction

  function automatic logic [TIMER_BITS-1:0] tinc(logic [TIMER_BITS-1:0] t);
    return (t == '1) ? t : t + 1'b1;
  endfunction

  function automatic rl_t drive_comp(rl_t s, logic rq, logic stable, relay_cfg_t c);
    rl_t  r;
    logic want;
    r    = s;
    want = rq & stable;
    if (!want && s.comp) begin
      r.comp      = 1'b0;
      r.since_off = '0;
      r.run       = '0;
    end else if (want && !s.comp && reached(s.since_off, c.short_cycle_delay) &&
                 s.fan && reached(s.since_fan, c.comp_on_delay)) begin
      r.comp = 1'b1;
    end
    return r;
  endfunction

  function automatic rl_t drive_fan(rl_t s, logic want, relay_cfg_t c);
    rl_t r;
    r = s;
    if (want && !s.fan) begin
      r.fan       = 1'b1;
      r.since_fan = '0;
    end else if (!want && s.fan && !s.comp && reached(s.since_off, c.fan_stop_delay)) begin
      r.fan = 1'b0;
    end
    return r;
  endfunction

  logic                  fan_q, comp_q;
  logic [TIMER_BITS-1:0] since_off_q, since_fan_q;
  logic [RUN_W-1:0]      run_q;
  logic [MS_W-1:0]       ms_q, ms_d;
  rl_t                   cur, nxt;
  logic [MS_W-1:0]       ms_inc;

  always_comb begin
    cur = '{fan: fan_q, comp: comp_q, since_off: since_off_q, since_fan: since_fan_q,
            run: run_q};
    nxt = cur;
    case (action_i)
      ACT_ALL_OFF: begin
        nxt = drive_fan(nxt, 1'b0, cfg_i);
        nxt = drive_comp(nxt, 1'b0, float_stable_i, cfg_i);
      end
      ACT_FAN_ONLY: begin
        nxt = drive_fan(nxt, 1'b1, cfg_i);
        nxt = drive_comp(nxt, 1'b0, float_stable_i, cfg_i);
      end
      ACT_FAN_HOLD: begin
        nxt = drive_fan(nxt, 1'b1, cfg_i);
      end
      ACT_COOL_ON: begin
        nxt = drive_fan(nxt, 1'b1, cfg_i);
        nxt = drive_comp(nxt, 1'b1, float_stable_i, cfg_i);
      end
      ACT_AUTO_OFF: begin
        nxt = drive_comp(nxt, 1'b0, float_stable_i, cfg_i);
        nxt = drive_fan(nxt, 1'b0, cfg_i);
      end
      ACT_AUTO_ON: begin
        nxt = drive_comp(nxt, 1'b1, float_stable_i, cfg_i);
        nxt = drive_fan(nxt, 1'b1, cfg_i);
      end
      default: begin
        nxt = cur;
      end
    endcase

    // Millisecond prescaler for the run-second count.
    ms_inc = (ms_q >= MS_MAX) ? MS_MAX : ms_q + 1'b1;
    if (!nxt.comp) begin
      ms_d = '0;
    end else if (ms_inc >= MS_PER_SECOND) begin
      if (nxt.run < RUN_MAX) begin
        nxt.run = nxt.run + 1'b1;
      end
      ms_d = '0;
    end else begin
      ms_d = ms_inc;
    end
  end

  assign out_o = '{fan: nxt.fan, comp: nxt.comp, run_seconds: nxt.run};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fan_q       <= 1'b0;
      comp_q      <= 1'b0;
      since_off_q <= '0;
      since_fan_q <= '0;
      run_q       <= '0;
      ms_q        <= '0;
    end else if (step_i) begin
      fan_q       <= nxt.fan;
      comp_q      <= nxt.comp;
      since_off_q <= tinc(nxt.since_off);
      since_fan_q <= tinc(nxt.since_fan);
      run_q       <= nxt.run;
      ms_q        <= ms_d;
    end
  end

endmodule

[sv/ac_fan_compressor_relay_control.sv]
`timescale 1ns / 1ps
// AC fan and compressor relay controller, one input beat per 1 ms tick.
// A beat taken into the input register moves on into the result register, from
// which its result beat is offered; a stalled sink holds it there.
// Throughput: one beat per cycle unless the sink stalls. The input register and
// result register form a two-stage pipeline; the tick's work sits between them.
// Reset (async, active low) clears the control state and loads register defaults.
module ac_fan_compressor_relay_control #(
  parameter int TIMER_BITS = 18,
  parameter int TEMP_BITS  = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  acfc_in_if.sink    in_i,
  acfc_out_if.source out_o,
  acfc_cfg_if.sink   cfg_i
);
  import acfc_pkg::*;

  // Compare width: holds the setpoint plus or minus the half band.
  localparam int CMP_W = TEMP_BITS + 2;

  // Configuration registers. Writes are taken in every cycle; the user only
  // writes while the pipeline is empty.
  logic [DEB_W-1:0]   debounce_q;
  logic [DELAY_W-1:0] comp_on_q, fan_off_q, short_cycle_q;
  logic [HYST_W-1:0]  hyst_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q    <= DEBOUNCE_RST;
      comp_on_q     <= COMP_ON_RST;
      fan_off_q     <= FAN_OFF_RST;
      short_cycle_q <= SHORT_CYCLE_RST;
      hyst_q        <= HYST_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_DEBOUNCE_TICKS:    debounce_q    <= cfg_i.wdata[DEB_W-1:0];
        REG_COMP_ON_DELAY:     comp_on_q     <= cfg_i.wdata;
        REG_FAN_OFF_DELAY:     fan_off_q     <= cfg_i.wdata;
        REG_SHORT_CYCLE_DELAY: short_cycle_q <= cfg_i.wdata;
        REG_HYSTERESIS_HALF:   hyst_q        <= cfg_i.wdata[HYST_W-1:0];
        default: begin
          // Writes to unknown indexes are dropped.
        end
      endcase
    end
  end

  // Input register stage. The tick is processed (and the state advances)
  // when it moves into the result register.
  logic                        in_valid_q;
  logic                        pin_q;
  logic signed [TEMP_IN_W-1:0] return_q, room_q, setpoint_q;
  logic                        use_room_q;
  logic [1:0]                  mode_q, sys_q;
  logic                        alarm_q, lockout_q;
  logic                        out_valid_q;
  logic                        advance;
  logic                        in_take;

  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      pin_q      <= in_i.float_pin_level;
      return_q   <= in_i.return_sample;
      room_q     <= in_i.room_temperature;
      setpoint_q <= in_i.setpoint;
      use_room_q <= in_i.use_room_temperature;
      mode_q     <= in_i.operating_mode;
      sys_q      <= in_i.unit_state;
      alarm_q    <= in_i.alarm_active;
      lockout_q  <= in_i.link_lockout;
    end
  end

  // Debounced float switch and return temperature tracking.
  logic                        float_stable;
  logic signed [TEMP_BITS-1:0] ret_air_temp;

  acfc_float_deb u_float_deb (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (advance),
    .pin_level_i      (pin_q),
    .debounce_ticks_i (debounce_q),
    .stable_o         (float_stable)
  );

  acfc_temp_track #(
    .TEMP_BITS (TEMP_BITS)
  ) u_temp_track (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (advance),
    .return_sample_i (return_q),
    .ret_temp_o      (ret_air_temp)
  );

  // Thermostat decision: which relays to request, and in which order.
  logic signed [CMP_W-1:0] ctrl_temp, on_level, off_level, hyst_ext;
  action_e                 action;

  always_comb begin
    hyst_ext  = $signed({{(CMP_W - HYST_W){1'b0}}, hyst_q});
    on_level  = CMP_W'(setpoint_q) + hyst_ext;
    off_level = CMP_W'(setpoint_q) - hyst_ext;
    ctrl_temp = use_room_q ? CMP_W'(room_q) : CMP_W'(ret_air_temp);

    if (lockout_q || alarm_q || (sys_q != SYS_ON)) begin
      action = ACT_ALL_OFF;
    end else begin
      case (mode_q)
        MODE_FAN: begin
          action = ACT_FAN_ONLY;
        end
        MODE_COOL: begin
          if (ctrl_temp <= off_level) begin
            action = ACT_FAN_ONLY;
          end else if (ctrl_temp >= on_level) begin
            action = ACT_COOL_ON;
          end else begin
            action = ACT_FAN_HOLD;
          end
        end
        MODE_AUTO: begin
          if (ctrl_temp <= off_level) begin
            action = ACT_AUTO_OFF;
          end else if (ctrl_temp >= on_level) begin
            action = ACT_AUTO_ON;
          end else begin
            action = ACT_HOLD;
          end
        end
        MODE_NO_ACTION: begin
          action = ACT_HOLD;
        end
        default: begin
          action = ACT_HOLD;
        end
      endcase
    end
  end

  relay_cfg_t relay_cfg;
  relay_out_t relay_out;

  assign relay_cfg = '{comp_on_delay: comp_on_q, fan_stop_delay: fan_off_q,
                       short_cycle_delay: short_cycle_q};

  acfc_relay #(
    .TIMER_BITS (TIMER_BITS)
  ) u_relay (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .action_i       (action),
    .float_stable_i (float_stable),
    .cfg_i          (relay_cfg),
    .out_o          (relay_out)
  );

  // Result register. It holds a beat while the sink stalls, and the input
  // stage keeps taking beats as long as this register can move on.
  logic             res_fan_q, res_comp_q, res_float_q;
  logic [RUN_W-1:0] res_run_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_fan_q   <= relay_out.fan;
      res_comp_q  <= relay_out.comp;
      res_float_q <= float_stable;
      res_run_q   <= relay_out.run_seconds;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.fan_drive    = res_fan_q;
  assign out_o.comp_drive   = res_comp_q;
  assign out_o.float_closed = res_float_q;
  assign out_o.run_seconds  = res_run_q;

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for ac_fan_compressor_relay_control: it sends 1 ms
// ticks and register writes, and checks every result beat against a local model.
// Depends on acfc_pkg and on the channel interfaces in acfc_if.sv.
module testbench;
  import acfc_pkg::*;

  // System state codes other than "on", which the package leaves unnamed.
  localparam logic [1:0] SYS_OFF     = 2'd1;
  localparam logic [1:0] SYS_SLEEP   = 2'd2;
  localparam logic [1:0] SYS_UNKNOWN = 2'd3;

  // The float switch pin is active low.
  localparam logic PIN_CLOSED = 1'b0;
  localparam logic PIN_OPEN   = 1'b1;

  localparam logic [DELAY_W-1:0] DELAY_MAX = '1;
  localparam logic [DEB_W-1:0]   DEB_MAX   = '1;

  // A correct run sends under two thousand ticks. The limit leaves ample room
  // for the receiver idling most of the time and for the long hold-off.
  localparam int CYCLE_LIMIT = 200_000;
  // Spare cycles waited after the last owed result beat has arrived.
  localparam int DRAIN_PAD   = 8;
  localparam int MAX_REPORTS = 10;
  // A little over one second of compressor run time.
  localparam int RUN_TICKS   = 1_010;

  // One 1 ms tick as it is offered on the input channel.
  typedef struct {
    logic                        pin;
    logic signed [TEMP_IN_W-1:0] ret;
    logic signed [TEMP_IN_W-1:0] room;
    logic signed [TEMP_IN_W-1:0] sp;
    logic                        use_room;
    logic [1:0]                  mode;
    logic [1:0]                  sys;
    logic                        alarm;
    logic                        lockout;
  } tick_t;

  // Relay outputs of one tick, in the order of the result fields.
  typedef struct packed {
    logic             fan;
    logic             comp;
    logic             float_closed;
    logic [RUN_W-1:0] run_s;
  } relay_state_t;

  logic clk_i;
  logic rst_ni;

  acfc_in_if  in_ch ();
  acfc_out_if res_ch ();
  acfc_cfg_if cfg_ch ();

  ac_fan_compressor_relay_control i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  // ---------------------------------------------------------------------------
  // Local copy of the controller: its register settings and its tick state.
  // ---------------------------------------------------------------------------
  logic [DEB_W-1:0]   debounce_cfg = DEBOUNCE_RST;
  logic [DELAY_W-1:0] on_delay_cfg = COMP_ON_RST;
  logic [DELAY_W-1:0] off_delay_cfg = FAN_OFF_RST;
  logic [DELAY_W-1:0] short_cycle_cfg = SHORT_CYCLE_RST;
  logic [HYST_W-1:0]  hyst_cfg = HYST_RST;

  logic               float_raw_q = 1'b0;
  logic               float_deb_q = 1'b0;
  logic [DEB_W-1:0]   float_age = '0;
  logic               fan_q = 1'b0;
  logic               comp_q = 1'b0;
  logic [DELAY_W-1:0] comp_off_age = '0;
  logic [DELAY_W-1:0] fan_on_age = '0;
  logic [MS_W-1:0]    ms_cnt = '0;
  logic [RUN_W-1:0]   run_secs = '0;
  int                 ret_temp = RETURN_TEMP_RST;

  // Relay states still owed by the block, oldest first.
  relay_state_t expected_relays_q[$];

  // Idle rates in percent, and the receiver's long hold-off.
  int src_idle_pct  = 19;
  int sink_idle_pct = 73;
  int hold_req      = 0;
  int hold_left     = 0;

  int cycle_cnt     = 0;
  int ticks_sent    = 0;
  int beats_checked = 0;
  int error_cnt     = 0;
  int comp_starts   = 0;
  int reg_writes    = 0;

  // ---------------------------------------------------------------------------
  // Relay control model. The compressor only runs with the float switch
  // closed. It waits out the anti-short-cycle time, and it needs the fan to
  // have run for the on-delay. The fan stops only after the off-delay that
  // follows a compressor stop.
  // ---------------------------------------------------------------------------
  function automatic void comp_request(input logic want_in);
    logic want;
    want = want_in && float_deb_q;
    if (!want && comp_q) begin
      comp_q       = 1'b0;
      comp_off_age = '0;
      run_secs     = '0;
    end else if (want && !comp_q && comp_off_age >= short_cycle_cfg && fan_q &&
                 fan_on_age >= on_delay_cfg) begin
      comp_q = 1'b1;
      comp_starts++;
    end
  endfunction

  function automatic void fan_request(input logic want);
    if (want && !fan_q) begin
      fan_q      = 1'b1;
      fan_on_age = '0;
    end else if (!want && fan_q && !comp_q && comp_off_age >= off_delay_cfg) begin
      fan_q = 1'b0;
    end
  endfunction

  // Advances the model by one tick and returns the relay state it reports.
  function automatic relay_state_t step_controller(input tick_t t);
    logic            closed_now;
    int              on_v;
    int              off_v;
    int              ctrl_temp;
    logic [MS_W-1:0] next_ms;
    relay_state_t    r;

    // The two sensor error codes never replace the last good return reading.
    if (t.ret != ERR_LOW_CODE && t.ret != ERR_HIGH_CODE) ret_temp = int'(t.ret);

    // Debounce. A change of the raw level restarts the stability count, and
    // the level is taken once it has held for debounce_cfg ticks. With zero
    // it is taken in the same tick.
    closed_now = (t.pin == PIN_CLOSED);
    if (closed_now != float_raw_q) begin
      float_age   = '0;
      float_raw_q = closed_now;
    end
    if (float_age >= debounce_cfg) float_deb_q = closed_now;

    if (t.lockout || t.alarm || t.sys != SYS_ON) begin
      fan_request(1'b0);
      comp_request(1'b0);
    end else begin
      on_v      = int'(t.sp) + int'(hyst_cfg);
      off_v     = int'(t.sp) - int'(hyst_cfg);
      ctrl_temp = t.use_room ? int'(t.room) : ret_temp;
      case (t.mode)
        MODE_FAN: begin
          fan_request(1'b1);
          comp_request(1'b0);
        end
        MODE_COOL: begin
          fan_request(1'b1);
          if (ctrl_temp <= off_v) comp_request(1'b0);
          else if (ctrl_temp >= on_v) comp_request(1'b1);
        end
        MODE_AUTO: begin
          // Inside the band nothing is requested, so both relays hold.
          if (ctrl_temp <= off_v) begin
            comp_request(1'b0);
            fan_request(1'b0);
          end else if (ctrl_temp >= on_v) begin
            comp_request(1'b1);
            fan_request(1'b1);
          end
        end
        default: ;  // no action: relays keep their state
      endcase
    end

    // Run seconds count from the last compressor start and saturate.
    next_ms = (ms_cnt >= MS_MAX) ? MS_MAX : ms_cnt + 1'b1;
    if (!comp_q) begin
      ms_cnt = '0;
    end else if (next_ms >= MS_PER_SECOND) begin
      if (run_secs < RUN_MAX) run_secs++;
      ms_cnt = '0;
    end else begin
      ms_cnt = next_ms;
    end

    r.fan          = fan_q;
    r.comp         = comp_q;
    r.float_closed = float_deb_q;
    r.run_s        = run_secs;

    // The tick timers advance at the end of the tick and stick at all ones.
    if (float_age != DEB_MAX) float_age++;
    if (comp_off_age != DELAY_MAX) comp_off_age++;
    if (fan_on_age != DELAY_MAX) fan_on_age++;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, cycle limit, receiver and result checker.
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d result beats still owed",
               cycle_cnt, expected_relays_q.size());
      $display("FAIL");
      $finish;
    end
  end

  // The receiver stalls at random. A hold-off request keeps ready low for
  // that many cycles, counted down here.
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Each accepted result beat is compared with the oldest owed relay state.
  always @(posedge clk_i) begin
    relay_state_t got;
    relay_state_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got.fan          = res_ch.fan_drive;
      got.comp         = res_ch.comp_drive;
      got.float_closed = res_ch.float_closed;
      got.run_s        = res_ch.run_seconds;
      if (expected_relays_q.size() == 0) begin
        error_cnt++;
        if (error_cnt <= MAX_REPORTS)
          $display("%0t: result beat with none owed: fan %b comp %b float %b run %0d",
                   $realtime, got.fan, got.comp, got.float_closed, got.run_s);
      end else begin
        want = expected_relays_q.pop_front();
        beats_checked++;
        if (got.fan !== want.fan || got.comp !== want.comp ||
            got.float_closed !== want.float_closed || got.run_s !== want.run_s) begin
          error_cnt++;
          if (error_cnt <= MAX_REPORTS)
            $display("%0t: beat %0d: fan %b/%b comp %b/%b float %b/%b run %0d/%0d (exp/act)",
                     $realtime, beats_checked,
                     want.fan, got.fan, want.comp, got.comp,
                     want.float_closed, got.float_closed, want.run_s, got.run_s);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic logic signed [TEMP_IN_W-1:0] to_temp(input int v);
    if (v > 2047) v = 2047;
    if (v < -2048) v = -2048;
    return TEMP_IN_W'(v);
  endfunction

  function automatic tick_t mk_tick(input logic pin, input int ret, input int room,
                                    input int sp, input logic use_room,
                                    input logic [1:0] mode, input logic [1:0] sys,
                                    input logic alarm, input logic lockout);
    tick_t t;
    t.pin      = pin;
    t.ret      = to_temp(ret);
    t.room     = to_temp(room);
    t.sp       = to_temp(sp);
    t.use_room = use_room;
    t.mode     = mode;
    t.sys      = sys;
    t.alarm    = alarm;
    t.lockout  = lockout;
    return t;
  endfunction

  // A tick with every field random, so that every input bit toggles.
  function automatic tick_t noise_tick();
    tick_t t;
    t.pin      = 1'($urandom());
    t.ret      = TEMP_IN_W'($urandom());
    t.room     = TEMP_IN_W'($urandom());
    t.sp       = TEMP_IN_W'($urandom());
    t.use_room = 1'($urandom());
    t.mode     = 2'($urandom());
    t.sys      = 2'($urandom());
    t.alarm    = 1'($urandom());
    t.lockout  = 1'($urandom());
    return t;
  endfunction

  // Offers one tick, with random idle cycles before it. Valid stays high after
  // the beat, so the next tick can follow straight on. The model takes the
  // tick at the edge where it is accepted.
  task automatic send_tick(input tick_t t);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid                <= 1'b1;
    in_ch.float_pin_level      <= t.pin;
    in_ch.return_sample        <= t.ret;
    in_ch.room_temperature     <= t.room;
    in_ch.setpoint             <= t.sp;
    in_ch.use_room_temperature <= t.use_room;
    in_ch.operating_mode       <= t.mode;
    in_ch.unit_state           <= t.sys;
    in_ch.alarm_active         <= t.alarm;
    in_ch.link_lockout         <= t.lockout;
    do @(posedge clk_i); while (!in_ch.ready);
    expected_relays_q.push_back(step_controller(t));
    ticks_sent++;
  endtask

  // Stops offering ticks and waits until every owed result beat has arrived.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (expected_relays_q.size() != 0);
    repeat (DRAIN_PAD) @(posedge clk_i);
  endtask

  // Writes one register. The model takes the new value at the same beat.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= CFG_DAT_W'(value);
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      REG_DEBOUNCE_TICKS:    debounce_cfg    = DEB_W'(value);
      REG_COMP_ON_DELAY:     on_delay_cfg    = DELAY_W'(value);
      REG_FAN_OFF_DELAY:     off_delay_cfg   = DELAY_W'(value);
      REG_SHORT_CYCLE_DELAY: short_cycle_cfg = DELAY_W'(value);
      REG_HYSTERESIS_HALF:   hyst_cfg        = HYST_W'(value);
      default: ;
    endcase
    reg_writes++;
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_timing(input int deb, input int on_dly, input int off_dly,
                                input int sc_dly, input int hyst);
    write_reg(REG_DEBOUNCE_TICKS, deb);
    write_reg(REG_COMP_ON_DELAY, on_dly);
    write_reg(REG_FAN_OFF_DELAY, off_dly);
    write_reg(REG_SHORT_CYCLE_DELAY, sc_dly);
    write_reg(REG_HYSTERESIS_HALF, hyst);
  endtask

  // Well-formed control sequences. Each sequence fixes a mode and a setpoint,
  // then walks the controlling temperature across the hysteresis band so
  // that the relays actually switch. The float switch mostly stays closed
  // and only bounces now and then. About one tick in twelve is pure noise.
  // Alarms, lockouts, sensor error codes and whole sequences with the float
  // switch open or the system not on break the pattern from time to time.
  task automatic run_scenarios(input int n_items);
    int         left;
    int         len;
    int         dir;
    int         step_max;
    int         sp;
    int         temp;
    int         ret_v;
    int         room_v;
    int         open_pct;
    logic       use_room;
    logic [1:0] mode;
    logic [1:0] sys;
    tick_t      t;
    left = n_items;
    while (left > 0) begin
      len      = $urandom_range(10, 60);
      mode     = 2'($urandom_range(3));
      sys      = ($urandom_range(9) == 0) ? 2'($urandom_range(3)) : SYS_ON;
      use_room = 1'($urandom_range(1));
      open_pct = ($urandom_range(6) == 0) ? 90 : 4;
      sp       = int'($urandom_range(600)) - 300;
      dir      = $urandom_range(1) ? 1 : -1;
      temp     = sp - dir * (int'(hyst_cfg) + 12);
      step_max = 2 + int'(hyst_cfg) / 12;
      for (int i = 0; i < len && left > 0; i++) begin
        if ($urandom_range(99) < 8) begin
          t = noise_tick();
        end else begin
          temp   += dir * int'($urandom_range(step_max));
          ret_v  = use_room ? int'($urandom_range(4095)) - 2048 : temp;
          room_v = use_room ? temp : int'($urandom_range(4095)) - 2048;
          if ($urandom_range(99) < 3)
            ret_v = $urandom_range(1) ? int'(ERR_LOW_CODE) : int'(ERR_HIGH_CODE);
          t = mk_tick(($urandom_range(99) < open_pct) ? PIN_OPEN : PIN_CLOSED,
                      ret_v, room_v, sp, use_room, mode, sys,
                      $urandom_range(49) == 0, $urandom_range(99) == 0);
        end
        send_tick(t);
        left--;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Hand-picked ticks. They cover the field extremes, every mode and system
  // state, both sensor error codes, alarm, lockout, the hysteresis band and a
  // float switch that opens.
  task automatic test_directed();
    // With the reset timing the anti-short-cycle time holds the compressor off.
    repeat (3) send_tick(mk_tick(PIN_CLOSED, 2047, 0, -2048, 1'b0, MODE_COOL, SYS_ON,
                                 1'b0, 1'b0));
    wait_idle();
    program_timing(2, 3, 3, 4, 8);
    repeat (4) send_tick(mk_tick(PIN_CLOSED, 2047, 0, 0, 1'b0, MODE_COOL, SYS_ON,
                                 1'b0, 1'b0));
    // Error codes would read as below the band. They are rejected, so the
    // compressor keeps running on the last good return temperature.
    send_tick(mk_tick(PIN_CLOSED, int'(ERR_HIGH_CODE), 0, 1400, 1'b0, MODE_COOL,
                      SYS_ON, 1'b0, 1'b0));
    send_tick(mk_tick(PIN_CLOSED, int'(ERR_LOW_CODE), 0, 1400, 1'b0, MODE_COOL,
                      SYS_ON, 1'b0, 1'b0));
    send_tick(mk_tick(PIN_CLOSED, -2048, 0, 0, 1'b0, MODE_COOL, SYS_ON, 1'b0, 1'b0));
    send_tick(mk_tick(PIN_CLOSED, 100, 0, 100, 1'b0, MODE_COOL, SYS_ON, 1'b0, 1'b0));
    // In auto mode the room temperature waits out the anti-short-cycle time.
    repeat (5) send_tick(mk_tick(PIN_CLOSED, 0, 2047, 0, 1'b1, MODE_AUTO, SYS_ON,
                                 1'b0, 1'b0));
    // The float switch opens. Once debounced, it drops the compressor.
    repeat (3) send_tick(mk_tick(PIN_OPEN, 0, 2047, 0, 1'b1, MODE_AUTO, SYS_ON,
                                 1'b0, 1'b0));
    send_tick(mk_tick(PIN_CLOSED, 0, -2048, 0, 1'b1, MODE_NO_ACTION, SYS_ON, 1'b0, 1'b0));
    send_tick(mk_tick(PIN_CLOSED, 0, 2047, 0, 1'b1, MODE_FAN, SYS_ON, 1'b0, 1'b0));
    send_tick(mk_tick(PIN_CLOSED, 0, 2047, 0, 1'b1, MODE_AUTO, SYS_ON, 1'b1, 1'b0));
    send_tick(mk_tick(PIN_CLOSED, 0, 2047, 0, 1'b1, MODE_AUTO, SYS_ON, 1'b0, 1'b1));
    send_tick(mk_tick(PIN_CLOSED, 0, 2047, 0, 1'b1, MODE_AUTO, SYS_OFF, 1'b0, 1'b0));
    send_tick(mk_tick(PIN_CLOSED, 0, 2047, 0, 1'b1, MODE_AUTO, SYS_SLEEP, 1'b0, 1'b0));
    send_tick(mk_tick(PIN_CLOSED, 0, 2047, 0, 1'b1, MODE_AUTO, SYS_UNKNOWN, 1'b0, 1'b0));
    send_tick(mk_tick(PIN_CLOSED, 0, -2048, 2047, 1'b1, MODE_AUTO, SYS_ON, 1'b0, 1'b0));
    wait_idle();
  endtask

  // Random sequences under one timing setting. The setting is written while
  // the block is idle.
  task automatic test_random_phase(input int n_items, input int deb, input int on_dly,
                                   input int off_dly, input int sc_dly, input int hyst);
    program_timing(deb, on_dly, off_dly, sc_dly, hyst);
    run_scenarios(n_items);
    wait_idle();
  endtask

  // The receiver holds off for a long time while ticks keep coming. The block
  // fills up and has to stall its input.
  task automatic test_backpressure();
    hold_req = 300;
    run_scenarios(150);
    wait_idle();
  endtask

  // Every timing register at its maximum for a few ticks with the system off,
  // then zero delays and no hysteresis. The compressor starts on the first
  // cooling tick and runs a little over one second, so run seconds step.
  task automatic test_run_seconds();
    program_timing(int'(DEB_MAX), int'(DELAY_MAX), int'(DELAY_MAX), int'(DELAY_MAX), 0);
    // Stopping the system restarts the off timer of a running compressor, and
    // the open pin restarts the float debounce if the switch was closed.
    repeat (5) send_tick(mk_tick(PIN_OPEN, 0, 0, 0, 1'b0, MODE_COOL, SYS_OFF,
                                 1'b0, 1'b0));
    wait_idle();
    program_timing(0, 0, 0, 0, 0);
    for (int i = 0; i < RUN_TICKS; i++)
      send_tick(mk_tick(PIN_CLOSED, int'($urandom_range(2047)),
                        int'($urandom_range(4095)) - 2048, -2048, 1'b0, MODE_COOL,
                        SYS_ON, 1'b0, 1'b0));
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni                     <= 1'b0;
    in_ch.valid                <= 1'b0;
    in_ch.float_pin_level      <= PIN_OPEN;
    in_ch.return_sample        <= '0;
    in_ch.room_temperature     <= '0;
    in_ch.setpoint             <= '0;
    in_ch.use_room_temperature <= 1'b0;
    in_ch.operating_mode       <= MODE_NO_ACTION;
    in_ch.unit_state           <= SYS_OFF;
    in_ch.alarm_active         <= 1'b0;
    in_ch.link_lockout         <= 1'b0;
    cfg_ch.valid               <= 1'b0;
    cfg_ch.index               <= REG_DEBOUNCE_TICKS;
    cfg_ch.wdata               <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sender idles lightly, receiver heavily.
    src_idle_pct  = 19;
    sink_idle_pct = 73;
    test_directed();
    test_random_phase(250, $urandom_range(6), $urandom_range(30), $urandom_range(30),
                      $urandom_range(40), $urandom_range(1, 24));

    // Roles swapped. Zero delays act in the same tick, and then the widest
    // hysteresis band is tried.
    src_idle_pct  = 73;
    sink_idle_pct = 19;
    test_random_phase(150, 0, 0, 0, 0, 0);
    test_random_phase(100, 1, $urandom_range(10), $urandom_range(10),
                      $urandom_range(10), 255);

    // No idling at all, then the long receiver stall and the long compressor run.
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_phase(180, $urandom_range(10), $urandom_range(60), $urandom_range(60),
                      $urandom_range(80), $urandom_range(40));
    test_backpressure();
    test_run_seconds();

    $display("Covered %0d ticks and %0d register writes; %0d result beats checked.",
             ticks_sent, reg_writes, beats_checked);
    $display("Compressor started %0d times, with a long stall and a run of over a second.",
             comp_starts);
    if (error_cnt == 0 && expected_relays_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d result beats missing", error_cnt,
               expected_relays_q.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule

[ac_fan_compressor_relay_control.f]
sv/acfc_pkg.sv
sv/acfc_if.sv
sv/acfc_float_deb.sv
sv/acfc_temp_track.sv
sv/acfc_relay.sv
sv/ac_fan_compressor_relay_control.sv
sim/testbench.sv
